/* src/array_list_insert_delete_find_unit_macros.svh */
// Assertion macros for the array list unit.
// Included by the modules that carry concurrent assertions; no dependencies.
`ifndef ARRAY_LIST_INSERT_DELETE_FIND_UNIT_MACROS_SVH
`define ARRAY_LIST_INSERT_DELETE_FIND_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define ALI_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define ALI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ALI_ASSERT(lbl, clk, rstn, prop, msg)
`define ALI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* src/ali_pkg.sv */
// Package for the array list unit: field widths, codes, FSM states and
// the command/status structs between controller and datapath. No dependencies.
package ali_pkg;

    localparam int ALI_CAPACITY = 128;
    localparam int OP_W     = 3;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_FIND   = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_UP,
        S_FLUSH_UP,
        S_INS_WR,
        S_SHIFT_DN,
        S_FLUSH_DN,
        S_SCAN,
        S_SCAN_LAST,
        S_RD,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_N_M1,
        IDX_POS,
        IDX_POS_M1,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } idx_sel_t;

    typedef enum logic [1:0] {
        WR_TAIL,
        WR_INS,
        WR_UP,
        WR_DN
    } wr_sel_t;

    typedef enum logic [1:0] {
        D_ZERO,
        D_RDATA,
        D_FOUND
    } data_sel_t;

    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef struct packed {
        status_t   status;
        data_sel_t data_sel;
        cnt_op_t   cnt_op;
    } fin_t;

    typedef struct packed {
        logic     load_req;
        logic     rd_en;
        idx_sel_t idx_sel;
        logic     wr_en;
        wr_sel_t  wr_sel;
        logic     out_load;
        fin_t     fin;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic full;
        logic ins_bad;
        logic rd_bad;
        logic ins_tail;
        logic del_tail;
        logic empty;
        logic up_end;
        logic dn_end;
        logic pend;
        logic match;
        logic out_free;
    } sts_t;

endpackage

/* src/ali_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ali_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/ali_ctrl.sv */
// Controller FSM of the array list unit: sequences shifts, scans and reads.
// Depends on ali_pkg and the assertion macro header.
`include "array_list_insert_delete_find_unit_macros.svh"

module ali_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ali_pkg::sts_t sts,
    output ali_pkg::cmd_t cmd
);
    import ali_pkg::*;

    state_t state_reg, state_next;
    fin_t   fin_reg, fin_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        fin_reg <= fin_next;
    end

    always_comb begin
        state_next   = state_reg;
        fin_next     = fin_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.idx_sel  = IDX_HOLD;
        cmd.wr_sel   = WR_TAIL;
        cmd.fin      = fin_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_DONE;
                fin_next   = '{ST_OK, D_ZERO, CNT_KEEP};
                unique case (sts.op)
                    OP_APPEND: begin
                        if (sts.full) begin
                            fin_next.status = ST_FULL;
                        end else begin
                            cmd.wr_en       = 1'b1;
                            cmd.wr_sel      = WR_TAIL;
                            fin_next.cnt_op = CNT_INC;
                        end
                    end
                    OP_INSERT: begin
                        if (sts.ins_bad) begin
                            fin_next.status = ST_BADPOS;
                        end else if (sts.full) begin
                            fin_next.status = ST_FULL;
                        end else if (sts.ins_tail) begin
                            cmd.wr_en       = 1'b1;
                            cmd.wr_sel      = WR_INS;
                            fin_next.cnt_op = CNT_INC;
                        end else begin
                            cmd.idx_sel = IDX_N_M1;
                            state_next  = S_SHIFT_UP;
                        end
                    end
                    OP_DELETE: begin
                        if (sts.rd_bad) begin
                            fin_next.status = ST_BADPOS;
                        end else if (sts.del_tail) begin
                            fin_next.cnt_op = CNT_DEC;
                        end else begin
                            cmd.idx_sel = IDX_POS;
                            state_next  = S_SHIFT_DN;
                        end
                    end
                    OP_FIND: begin
                        if (sts.empty) begin
                            fin_next.status = ST_NOTFOUND;
                        end else begin
                            cmd.idx_sel = IDX_ZERO;
                            state_next  = S_SCAN;
                        end
                    end
                    OP_READ: begin
                        if (sts.rd_bad) begin
                            fin_next.status = ST_BADPOS;
                        end else begin
                            cmd.idx_sel = IDX_POS_M1;
                            state_next  = S_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SHIFT_UP: begin
                cmd.rd_en  = 1'b1;
                cmd.wr_en  = sts.pend;
                cmd.wr_sel = WR_UP;
                if (sts.up_end) begin
                    state_next = S_FLUSH_UP;
                end else begin
                    cmd.idx_sel = IDX_DEC;
                end
            end
            S_FLUSH_UP: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_UP;
                state_next = S_INS_WR;
            end
            S_INS_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_INS;
                fin_next   = '{ST_OK, D_ZERO, CNT_INC};
                state_next = S_DONE;
            end
            S_SHIFT_DN: begin
                cmd.rd_en  = 1'b1;
                cmd.wr_en  = sts.pend;
                cmd.wr_sel = WR_DN;
                if (sts.dn_end) begin
                    state_next = S_FLUSH_DN;
                end else begin
                    cmd.idx_sel = IDX_INC;
                end
            end
            S_FLUSH_DN: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_DN;
                fin_next   = '{ST_OK, D_ZERO, CNT_DEC};
                state_next = S_DONE;
            end
            S_SCAN: begin
                if (sts.pend && sts.match) begin
                    fin_next   = '{ST_OK, D_FOUND, CNT_KEEP};
                    state_next = S_DONE;
                end else begin
                    cmd.rd_en = 1'b1;
                    if (sts.dn_end) begin
                        state_next = S_SCAN_LAST;
                    end else begin
                        cmd.idx_sel = IDX_INC;
                    end
                end
            end
            S_SCAN_LAST: begin
                if (sts.match) begin
                    fin_next = '{ST_OK, D_FOUND, CNT_KEEP};
                end else begin
                    fin_next = '{ST_NOTFOUND, D_ZERO, CNT_KEEP};
                end
                state_next = S_DONE;
            end
            S_RD: begin
                cmd.rd_en  = 1'b1;
                fin_next   = '{ST_OK, D_RDATA, CNT_KEEP};
                state_next = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `ALI_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> state_reg == S_IDLE, "reset did not return to idle")
    `ALI_ASSERT(a_accept_decode, aclk, aresetn, (s_valid && s_ready) |=> state_reg == S_DECODE, "accepted request not decoded")
    `ALI_ASSERT(a_done_idle, aclk, aresetn, (state_reg == S_DONE && sts.out_free) |=> state_reg == S_IDLE, "finished request not released")

endmodule

/* src/ali_dpath.sv */
// Datapath of the array list unit: request and result registers, length count,
// index counters, entry RAM. Depends on ali_pkg, ali_ram and the macro header.
`include "array_list_insert_delete_find_unit_macros.svh"

module ali_dpath #(
    parameter int CAPACITY = ali_pkg::ALI_CAPACITY
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [ali_pkg::OP_W-1:0]          s_op,
    input  logic signed [ali_pkg::VAL_W-1:0]  s_value,
    input  logic [ali_pkg::POS_W-1:0]         s_position,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ali_pkg::STATUS_W-1:0]      m_status,
    output logic signed [ali_pkg::VAL_W-1:0]  m_data,
    output logic [ali_pkg::COUNT_W-1:0]       m_count,
    input  ali_pkg::cmd_t                     cmd,
    output ali_pkg::sts_t                     sts
);
    import ali_pkg::*;

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    logic [OP_W-1:0]     op_reg;
    logic [VAL_W-1:0]    value_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       last_reg;
    logic                pend_reg;
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [VAL_W-1:0]    data_reg, data_next;

    logic [CW-1:0]    pos_ext, n_ext;
    logic [AW-1:0]    pos_m1, pos_a, n_m1, tail_a;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [VAL_W-1:0] ram_wdata, ram_rdata;

    assign pos_ext = CW'(pos_reg);
    assign n_ext   = CW'(count_reg);
    assign pos_m1  = AW'(pos_ext - CW'(1));
    assign pos_a   = AW'(pos_ext);
    assign n_m1    = AW'(n_ext - CW'(1));
    assign tail_a  = AW'(count_reg);

    always_comb begin
        sts          = '0;
        sts.op       = op_reg;
        sts.full     = (n_ext == CW'(CAPACITY));
        sts.ins_bad  = (pos_reg == '0) || (pos_ext > n_ext + CW'(1));
        sts.rd_bad   = (pos_reg == '0) || (pos_ext > n_ext);
        sts.ins_tail = (pos_ext == n_ext + CW'(1));
        sts.del_tail = (pos_ext == n_ext);
        sts.empty    = (count_reg == '0);
        sts.up_end   = (idx_reg == pos_m1);
        sts.dn_end   = (idx_reg == n_m1);
        sts.pend     = pend_reg;
        sts.match    = (ram_rdata == value_reg);
        sts.out_free = !m_valid_reg || m_ready;
    end

    always_comb begin
        unique case (cmd.idx_sel)
            IDX_HOLD:   idx_next = idx_reg;
            IDX_N_M1:   idx_next = n_m1;
            IDX_POS:    idx_next = pos_a;
            IDX_POS_M1: idx_next = pos_m1;
            IDX_ZERO:   idx_next = '0;
            IDX_INC:    idx_next = idx_reg + AW'(1);
            IDX_DEC:    idx_next = idx_reg - AW'(1);
            default:    idx_next = idx_reg;
        endcase
    end

    always_comb begin
        ram_we    = cmd.wr_en;
        ram_wdata = value_reg;
        unique case (cmd.wr_sel)
            WR_TAIL: ram_waddr = tail_a;
            WR_INS:  ram_waddr = pos_m1;
            WR_UP: begin
                ram_waddr = last_reg + AW'(1);
                ram_wdata = ram_rdata;
            end
            WR_DN: begin
                ram_waddr = last_reg - AW'(1);
                ram_wdata = ram_rdata;
            end
            default: ram_waddr = tail_a;
        endcase
    end

    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (cmd.fin.data_sel)
            D_ZERO:  data_next = '0;
            D_RDATA: data_next = ram_rdata;
            D_FOUND: data_next = VAL_W'(last_reg) + VAL_W'(1);
            default: data_next = '0;
        endcase
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            unique case (cmd.fin.cnt_op)
                CNT_KEEP: count_next = count_reg;
                CNT_INC:  count_next = count_reg + CNT_W'(1);
                CNT_DEC:  count_next = count_reg - CNT_W'(1);
                default:  count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            pend_reg    <= cmd.rd_en;
            m_valid_reg <= m_valid_next;
        end
        if (cmd.load_req) begin
            op_reg    <= s_op;
            value_reg <= s_value;
            pos_reg   <= s_position;
        end
        idx_reg <= idx_next;
        if (cmd.rd_en) begin
            last_reg <= idx_reg;
        end
        if (cmd.out_load) begin
            status_reg <= cmd.fin.status;
            data_reg   <= data_next;
        end
    end

    ali_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign m_valid  = m_valid_reg;
    assign m_status = status_reg;
    assign m_data   = data_reg;
    assign m_count  = COUNT_W'(count_reg);

    `ALI_ASSERT(a_count_cap, aclk, aresetn, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `ALI_ASSERT(a_count_inc, aclk, aresetn, (cmd.out_load && cmd.fin.cnt_op == CNT_INC) |=> (count_reg == $past(count_reg) + CNT_W'(1)), "count did not grow")
    `ALI_ASSERT(a_hold_result, aclk, aresetn, (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(data_reg)), "stalled result not held")

endmodule

/* src/array_list_insert_delete_find_unit.sv */
// Array list unit, top level: ordered list of signed words in a RAM.
// Request channel s_*: op (append, insert, delete, find, read), value, position.
// Result channel m_*: status, data (word read or 1-based position found), count.
// One result per request, in request order.
// Append, errors, unused ops and find on an empty list do not walk the RAM;
// read does a single RAM read. For position p, insert shifts the entries from
// p on up and delete shifts those after p down, neither at the tail; find
// stops at its first match.
// Insert, delete and find walk the entry RAM one entry per cycle through its
// single read port.
// One request is processed at a time; s_ready is high while idle, and a new
// request is accepted while the previous result still waits in the output
// register. A stalled m_ready holds the result and keeps the unit from
// finishing the next request.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// result; entry contents are not cleared, since only entries below the count
// are ever read.
// Depends on ali_pkg, ali_ctrl, ali_dpath and ali_ram.
module array_list_insert_delete_find_unit #(
    parameter int CAPACITY = ali_pkg::ALI_CAPACITY
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ali_pkg::OP_W-1:0]          s_op,
    input  logic signed [ali_pkg::VAL_W-1:0]  s_value,
    input  logic [ali_pkg::POS_W-1:0]         s_position,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ali_pkg::STATUS_W-1:0]      m_status,
    output logic signed [ali_pkg::VAL_W-1:0]  m_data,
    output logic [ali_pkg::COUNT_W-1:0]       m_count
);
    import ali_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ali_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ali_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_op       (s_op),
        .s_value    (s_value),
        .s_position (s_position),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_data     (m_data),
        .m_count    (m_count),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule
